@@ hdl/modbus_rtu_read_master_assert.svh @@
// Assertion macros shared by the read master modules.
`ifndef MODBUS_RTU_READ_MASTER_ASSERT_SVH
`define MODBUS_RTU_READ_MASTER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define MRM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mrm assertion failed");

// A condition that must be followed by a consequence in the next cycle.
`define MRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mrm assertion failed");

`endif

@@ hdl/mrm_pkg.sv @@
// Types, codes and constants shared by the read master modules.
package mrm_pkg;

  localparam int unsigned TIMEOUT_W     = 20;
  localparam int unsigned DEF_BUF_BYTES = 16;
  localparam logic [TIMEOUT_W-1:0] DEF_TIMEOUT = 20'd50000;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Input opcodes.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_REG  = 2'd1;
  localparam logic [1:0] KIND_STAT = 2'd2;

  // Completion status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TOOLONG = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_CRC     = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  slave_addr;
    logic [7:0]  function_code;
    logic [15:0] register_address;
    logic [15:0] register_count;
    logic [7:0]  rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  tx_byte;
    logic [15:0] register_value;
    logic [2:0]  register_index;
    logic [1:0]  status_code;
    logic        last_result;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       start;
    logic       rx;
    logic       tick;
    logic       timeout;
    logic       emit_tx;
    logic       emit_stat;
    logic [1:0] stat_code;
    logic       rd_hi;
    logic       rd_lo;
    logic       emit_word;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic waiting;
    logic timeout_hit;
    logic rx_last;
    logic crc_ok;
    logic out_free;
    logic tx_last;
    logic too_long;
    logic no_regs;
    logic word_last;
  } sts_t;

endpackage

@@ hdl/modbus_rtu_read_master.sv @@
// Modbus RTU read master: request frame out, reply collection, CRC check, word unpack.
// A start word gives eight tx-byte results (plus a status result if the reply would be too
// long); the next word is taken once all are loaded. Received bytes and ticks are taken in
// idle; a completing byte with a good CRC adds two buffer reads (on its single read port)
// and a word result per register word, then a status; a bad CRC or timeout gives it alone.
// Reset clears control and sets the byte timeout to 50000; the reply buffer is not cleared.
module modbus_rtu_read_master #(
  parameter int unsigned REPLY_BUFFER_BYTES = mrm_pkg::DEF_BUF_BYTES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mrm_pkg::TIMEOUT_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mrm_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mrm_pkg::out_t                 out_data_o
);

  mrm_pkg::cmd_t cmd;
  mrm_pkg::sts_t sts;

  mrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (in_data_i.opcode),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mrm_datapath #(
    .BUF_BYTES (REPLY_BUFFER_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ hdl/mrm_ctrl.sv @@
// Controller state machine of the read master.
`include "modbus_rtu_read_master_assert.svh"

module mrm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    opcode_i,
  output logic          in_ready_o,
  input  mrm_pkg::sts_t sts_i,
  output mrm_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TX,
    S_STAT,
    S_RDHI,
    S_RDLO,
    S_WORD
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] code_q, code_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    code_d  = code_q;
    cmd_o.stat_code = code_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (opcode_i)
            mrm_pkg::OP_START: begin
              cmd_o.start = 1'b1;
              state_d     = S_TX;
            end
            mrm_pkg::OP_BYTE: begin
              if (sts_i.waiting) begin
                cmd_o.rx = 1'b1;
                if (sts_i.rx_last) begin
                  if (!sts_i.crc_ok) begin
                    code_d  = mrm_pkg::ST_CRC;
                    state_d = S_STAT;
                  end else if (sts_i.no_regs) begin
                    code_d  = mrm_pkg::ST_OK;
                    state_d = S_STAT;
                  end else begin
                    state_d = S_RDHI;
                  end
                end
              end
            end
            mrm_pkg::OP_TICK: begin
              if (sts_i.waiting) begin
                if (sts_i.timeout_hit) begin
                  cmd_o.timeout = 1'b1;
                  code_d        = mrm_pkg::ST_TIMEOUT;
                  state_d       = S_STAT;
                end else begin
                  cmd_o.tick = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_TX: begin
        if (sts_i.out_free) begin
          cmd_o.emit_tx = 1'b1;
          if (sts_i.tx_last) begin
            if (sts_i.too_long) begin
              code_d  = mrm_pkg::ST_TOOLONG;
              state_d = S_STAT;
            end else begin
              state_d = S_IDLE;
            end
          end
        end
      end
      S_STAT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_stat = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_RDHI: begin
        cmd_o.rd_hi = 1'b1;
        state_d     = S_RDLO;
      end
      S_RDLO: begin
        cmd_o.rd_lo = 1'b1;
        state_d     = S_WORD;
      end
      S_WORD: begin
        if (sts_i.out_free) begin
          cmd_o.emit_word = 1'b1;
          if (sts_i.word_last) begin
            code_d  = mrm_pkg::ST_OK;
            state_d = S_STAT;
          end else begin
            state_d = S_RDHI;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= mrm_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  `MRM_ASSERT_NEXT(a_start_sends, clk_i, rst_ni,
                   in_valid_i && in_ready_o && opcode_i == mrm_pkg::OP_START,
                   state_q == S_TX)
  `MRM_ASSERT_NEXT(a_read_pair, clk_i, rst_ni, state_q == S_RDHI, state_q == S_RDLO)

endmodule

@@ hdl/mrm_datapath.sv @@
// Datapath of the read master: frame build, reply buffer, CRC and result register.
`include "modbus_rtu_read_master_assert.svh"

module mrm_datapath #(
  parameter int unsigned BUF_BYTES = mrm_pkg::DEF_BUF_BYTES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mrm_pkg::TIMEOUT_W-1:0] cfg_data_i,
  input  mrm_pkg::in_t                  in_data_i,
  input  mrm_pkg::cmd_t                 cmd_i,
  output mrm_pkg::sts_t                 sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mrm_pkg::out_t                 out_data_o
);

  // Replies never exceed 21 bytes, so at most eight words plus status come out.
  localparam int unsigned USABLE   = (BUF_BYTES < 21) ? BUF_BYTES : 21;
  localparam int unsigned AW       = $clog2(USABLE);
  localparam int unsigned RCV_W    = $clog2(USABLE + 1);
  localparam int unsigned MAX_REGS = (USABLE - 5) / 2;

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ mrm_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic [7:0]                   reply_mem [USABLE];
  logic                         waiting_q;
  logic [RCV_W-1:0]             rcv_q, exp_q;
  logic [15:0]                  run_crc_q, req_crc_q;
  logic [mrm_pkg::TIMEOUT_W-1:0] idle_q, timeout_q;
  logic [2:0]                   idx_q, w_q;
  logic                         too_long_q;
  logic [7:0]                   slave_q, func_q, prev_q, hi_q, rdata_q;
  logic [15:0]                  addr_q, cnt_q;
  logic                         out_valid_q;
  mrm_pkg::out_t                out_q;

  logic             too_long_c;
  logic [RCV_W-1:0] exp_c;
  logic             rx_last;
  logic             crc_upd;
  logic [7:0]       txb;
  logic [AW-1:0]    rd_addr;
  logic             load;
  mrm_pkg::out_t    out_d;

  assign too_long_c = (in_data_i.register_count > 16'(MAX_REGS));
  assign exp_c      = RCV_W'(17'd5 + {in_data_i.register_count, 1'b0});
  assign rx_last    = ((rcv_q + RCV_W'(1)) == exp_q);
  assign crc_upd    = (({1'b0, rcv_q} + (RCV_W + 1)'(2)) < {1'b0, exp_q});
  assign rd_addr    = cmd_i.rd_lo ? AW'(5'd4 + 5'({w_q, 1'b0}))
                                  : AW'(5'd3 + 5'({w_q, 1'b0}));
  assign load       = cmd_i.emit_tx | cmd_i.emit_stat | cmd_i.emit_word;

  always_comb begin
    case (idx_q)
      3'd0:    txb = slave_q;
      3'd1:    txb = func_q;
      3'd2:    txb = addr_q[15:8];
      3'd3:    txb = addr_q[7:0];
      3'd4:    txb = cnt_q[15:8];
      3'd5:    txb = cnt_q[7:0];
      3'd6:    txb = req_crc_q[7:0];
      default: txb = req_crc_q[15:8];
    endcase
  end

  always_comb begin
    out_d = '0;
    if (cmd_i.emit_tx) begin
      out_d.result_kind = mrm_pkg::KIND_TX;
      out_d.tx_byte     = txb;
      out_d.last_result = (idx_q == 3'd7) && !too_long_q;
    end else if (cmd_i.emit_word) begin
      out_d.result_kind    = mrm_pkg::KIND_REG;
      out_d.register_value = {hi_q, rdata_q};
      out_d.register_index = w_q;
    end else begin
      out_d.result_kind = mrm_pkg::KIND_STAT;
      out_d.status_code = cmd_i.stat_code;
      out_d.last_result = 1'b1;
    end
  end

  always_comb begin
    sts_o             = '0;
    sts_o.waiting     = waiting_q;
    sts_o.timeout_hit = (idle_q >= timeout_q);
    sts_o.rx_last     = rx_last;
    sts_o.crc_ok      = ({in_data_i.rx_byte, prev_q} == run_crc_q);
    sts_o.out_free    = !out_valid_q || out_ready_i;
    sts_o.tx_last     = (idx_q == 3'd7);
    sts_o.too_long    = too_long_q;
    sts_o.no_regs     = (cnt_q[3:0] == 4'd0);
    sts_o.word_last   = ((4'(w_q) + 4'd1) == cnt_q[3:0]);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q   <= 1'b0;
      rcv_q       <= '0;
      exp_q       <= '0;
      run_crc_q   <= mrm_pkg::CRC_INIT;
      idle_q      <= '0;
      timeout_q   <= mrm_pkg::DEF_TIMEOUT;
      idx_q       <= '0;
      w_q         <= '0;
      too_long_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_data_i;
      end
      if (cmd_i.start) begin
        waiting_q  <= !too_long_c;
        rcv_q      <= '0;
        exp_q      <= too_long_c ? '0 : exp_c;
        run_crc_q  <= mrm_pkg::CRC_INIT;
        idle_q     <= '0;
        idx_q      <= '0;
        too_long_q <= too_long_c;
      end
      if (cmd_i.rx) begin
        idle_q <= '0;
        if (rx_last) begin
          waiting_q <= 1'b0;
          rcv_q     <= '0;
          exp_q     <= '0;
          run_crc_q <= mrm_pkg::CRC_INIT;
          w_q       <= '0;
        end else begin
          rcv_q <= rcv_q + RCV_W'(1);
          if (crc_upd) begin
            run_crc_q <= crc_add(run_crc_q, in_data_i.rx_byte);
          end
        end
      end
      if (cmd_i.tick) begin
        idle_q <= idle_q + mrm_pkg::TIMEOUT_W'(1);
      end
      if (cmd_i.timeout) begin
        waiting_q <= 1'b0;
        rcv_q     <= '0;
        exp_q     <= '0;
        run_crc_q <= mrm_pkg::CRC_INIT;
        idle_q    <= '0;
      end
      if (cmd_i.emit_tx) begin
        idx_q <= idx_q + 3'd1;
      end
      if (cmd_i.emit_word) begin
        w_q <= w_q + 3'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      slave_q   <= in_data_i.slave_addr;
      func_q    <= in_data_i.function_code;
      addr_q    <= in_data_i.register_address;
      cnt_q     <= in_data_i.register_count;
      req_crc_q <= mrm_pkg::CRC_INIT;
    end
    if (cmd_i.emit_tx && (idx_q < 3'd6)) begin
      req_crc_q <= crc_add(req_crc_q, txb);
    end
    if (cmd_i.rx) begin
      reply_mem[rcv_q[AW-1:0]] <= in_data_i.rx_byte;
      prev_q                   <= in_data_i.rx_byte;
    end
    if (cmd_i.rd_hi || cmd_i.rd_lo) begin
      rdata_q <= reply_mem[rd_addr];
    end
    if (cmd_i.rd_lo) begin
      hi_q <= rdata_q;
    end
    if (load) begin
      out_q <= out_d;
    end
  end

  `MRM_ASSERT(a_rcv_in_range, clk_i, rst_ni, !waiting_q || (rcv_q < exp_q))
  `MRM_ASSERT(a_idle_clean, clk_i, rst_ni, waiting_q || (rcv_q == '0 && idle_q == '0))
  `MRM_ASSERT(a_no_overwrite, clk_i, rst_ni, !(load && out_valid_q) || out_ready_i)

endmodule
